FILE: rtl/core/tgp_pkg.sv
// tgp_pkg: command codes, heading codes, word types and controller states
// for the turtle grid plotter. No dependencies.

package tgp_pkg;

	// command codes carried in the func field
	localparam logic [2:0] FUNC_PEN_UP    = 3'd0;
	localparam logic [2:0] FUNC_PEN_DOWN  = 3'd1;
	localparam logic [2:0] FUNC_TURN_R    = 3'd2;
	localparam logic [2:0] FUNC_TURN_L    = 3'd3;
	localparam logic [2:0] FUNC_MOVE      = 3'd4;
	localparam logic [2:0] FUNC_READ      = 3'd5;

	// heading codes
	localparam logic [1:0] HEAD_EAST  = 2'd0;
	localparam logic [1:0] HEAD_SOUTH = 2'd1;
	localparam logic [1:0] HEAD_WEST  = 2'd2;
	localparam logic [1:0] HEAD_NORTH = 2'd3;

	typedef struct packed {
		logic [2:0] func;
		logic [5:0] step_count;
		logic [5:0] read_row;
		logic [5:0] read_col;
	} cmd_t;

	typedef struct packed {
		logic       cell_value;
		logic [5:0] row_now;
		logic [5:0] col_now;
		logic [1:0] heading_now;
		logic       pen_now;
		logic       clipped;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_HORZ,
		ST_VERT,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/core/turtle_grid_plotter.sv
// turtle_grid_plotter: top level of the turtle plotter; command decode,
// move walker and result register. Depends on tgp_pkg and tgp_grid_mem.
//
//   channel  dir  handshake            word
//   cmd      in   cmd_valid/cmd_stall  tgp_pkg::cmd_t
//   rsp      out  rsp_valid/rsp_stall  tgp_pkg::rsp_t
//
// One command at a time. A cell read passes ST_READ and a drawing horizontal
// move ST_HORZ; a drawing vertical move stays in ST_VERT row by row, since the
// grid memory writes one row per cycle. Every command ends in ST_DONE.
// Reset clears the grid through per-row valid bits, with no clearing pass.
// A waiting result holds in the output register while the next command runs.

module turtle_grid_plotter #(
	parameter int GRID_SIZE = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  tgp_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tgp_pkg::rsp_t rsp
);

	import tgp_pkg::*;

	localparam int PW = $clog2(GRID_SIZE);
	localparam int XW = (PW > 6) ? PW : 6;
	localparam int SW = XW + 1;

	state_t state_q, state_d;

	logic [PW-1:0] row_q, col_q;
	logic [1:0]    heading_q;
	logic          pen_q;

	logic [PW-1:0] start_c_q, tgt_r_q, tgt_c_q;
	logic [PW-1:0] iss_q, rd_row_s1;
	logic          south_q;
	logic          clip_q, cell_q, rd_ok_q;
	logic [PW-1:0] rd_col_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic accept, rsp_load;
	logic mem_rd_en, mem_wr_en;
	logic [PW-1:0] mem_rd_addr;
	logic [GRID_SIZE-1:0] mem_rd_data, mem_wr_data;
	logic [GRID_SIZE-1:0] span_mask, bit_mask;

	// move target and clip
	logic [SW-1:0] n_x, row_x, col_x, sum_r, sum_c;
	logic [PW-1:0] r1, c1;
	logic          clip_d;
	logic [XW-1:0] rrow_x, rcol_x, out_row_x, out_col_x;
	logic          read_ok;
	logic          go_horz, go_vert;

	assign accept = cmd_valid && !cmd_stall;

	always_comb begin
		n_x   = SW'(cmd.step_count);
		row_x = SW'(row_q);
		col_x = SW'(col_q);
		sum_r = row_x + n_x;
		sum_c = col_x + n_x;
		r1    = row_q;
		c1    = col_q;
		clip_d = 1'b0;
		unique case (heading_q)
			HEAD_EAST: begin
				if (sum_c > SW'(GRID_SIZE - 1)) begin
					c1 = PW'(GRID_SIZE - 1);
					clip_d = 1'b1;
				end else begin
					c1 = sum_c[PW-1:0];
				end
			end
			HEAD_SOUTH: begin
				if (sum_r > SW'(GRID_SIZE - 1)) begin
					r1 = PW'(GRID_SIZE - 1);
					clip_d = 1'b1;
				end else begin
					r1 = sum_r[PW-1:0];
				end
			end
			HEAD_WEST: begin
				if (n_x > col_x) begin
					c1 = '0;
					clip_d = 1'b1;
				end else begin
					c1 = col_q - n_x[PW-1:0];
				end
			end
			HEAD_NORTH: begin
				if (n_x > row_x) begin
					r1 = '0;
					clip_d = 1'b1;
				end else begin
					r1 = row_q - n_x[PW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rrow_x  = XW'(cmd.read_row);
		rcol_x  = XW'(cmd.read_col);
		read_ok = (SW'(rrow_x) < SW'(GRID_SIZE)) && (SW'(rcol_x) < SW'(GRID_SIZE));
		go_horz = (cmd.func == FUNC_MOVE) && pen_q && (c1 != col_q);
		go_vert = (cmd.func == FUNC_MOVE) && pen_q && (r1 != row_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.func == FUNC_READ) begin
						state_d = ST_READ;
					end else if (go_horz) begin
						state_d = ST_HORZ;
					end else if (go_vert) begin
						state_d = ST_VERT;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_HORZ: state_d = ST_DONE;
			ST_VERT: begin
				if (iss_q == tgt_r_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd_stall   = 1'b1;
		rsp_load    = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = iss_q;
		mem_wr_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd.func == FUNC_READ) begin
					mem_rd_en   = cmd_valid && read_ok;
					mem_rd_addr = rrow_x[PW-1:0];
				end else begin
					mem_rd_en   = cmd_valid && (go_horz || go_vert);
					mem_rd_addr = row_q;
				end
			end
			ST_READ: begin
			end
			ST_HORZ: mem_wr_en = 1'b1;
			ST_VERT: begin
				mem_wr_en = 1'b1;
				mem_rd_en = (iss_q != tgt_r_q);
			end
			ST_DONE: rsp_load = !rsp_valid_q || !rsp_stall;
			default: begin
			end
		endcase
	end

	// marks for the current write: span of a row, or one column
	always_comb begin
		for (int i = 0; i < GRID_SIZE; i++) begin
			bit_mask[i] = (SW'(i) == SW'(start_c_q));
			if (SW'(tgt_c_q) > SW'(start_c_q)) begin
				span_mask[i] = (SW'(i) >= SW'(start_c_q)) && (SW'(i) < SW'(tgt_c_q));
			end else begin
				span_mask[i] = (SW'(i) > SW'(tgt_c_q)) && (SW'(i) <= SW'(start_c_q));
			end
		end
		mem_wr_data = mem_rd_data | ((state_q == ST_VERT) ? bit_mask : span_mask);
	end

	tgp_grid_mem #(
		.GRID_SIZE(GRID_SIZE)
	) u_grid (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (rd_row_s1),
		.wr_data (mem_wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			heading_q   <= HEAD_EAST;
			pen_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (cmd.func)
					FUNC_PEN_UP:   pen_q <= 1'b0;
					FUNC_PEN_DOWN: pen_q <= 1'b1;
					FUNC_TURN_R:   heading_q <= heading_q + 2'd1;
					FUNC_TURN_L:   heading_q <= heading_q - 2'd1;
					FUNC_MOVE: begin
						row_q <= r1;
						col_q <= c1;
					end
					default: begin
					end
				endcase
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// move walker and per-command payload
	always_ff @(posedge clk) begin
		if (accept) begin
			start_c_q <= col_q;
			tgt_r_q   <= r1;
			tgt_c_q   <= c1;
			south_q   <= (r1 > row_q);
			rd_row_s1 <= row_q;
			iss_q     <= (r1 > row_q) ? row_q + PW'(1) : row_q - PW'(1);
			clip_q    <= (cmd.func == FUNC_MOVE) && clip_d;
			cell_q    <= 1'b0;
			rd_ok_q   <= read_ok;
			rd_col_q  <= rcol_x[PW-1:0];
		end
		if (state_q == ST_VERT && iss_q != tgt_r_q) begin
			rd_row_s1 <= iss_q;
			iss_q     <= south_q ? iss_q + PW'(1) : iss_q - PW'(1);
		end
		if (state_q == ST_READ) begin
			cell_q <= rd_ok_q && mem_rd_data[rd_col_q];
		end
		if (rsp_load) begin
			rsp_q.cell_value  <= cell_q;
			rsp_q.row_now     <= out_row_x[5:0];
			rsp_q.col_now     <= out_col_x[5:0];
			rsp_q.heading_now <= heading_q;
			rsp_q.pen_now     <= pen_q;
			rsp_q.clipped     <= clip_q;
		end
	end

	assign out_row_x = XW'(row_q);
	assign out_col_x = XW'(col_q);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/core/tgp_grid_mem.sv
// tgp_grid_mem: one-bit drawing grid stored as one memory row per grid row.
// One write and one registered read per cycle; per-row valid bits make
// unwritten rows read as zero after reset. Depends on nothing.

module tgp_grid_mem #(
	parameter int GRID_SIZE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(GRID_SIZE)-1:0] rd_addr,
	output logic [GRID_SIZE-1:0]         rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(GRID_SIZE)-1:0] wr_addr,
	input  logic [GRID_SIZE-1:0]         wr_data
);

	logic [GRID_SIZE-1:0] mem [GRID_SIZE];
	logic [GRID_SIZE-1:0] row_vld_q;
	logic [GRID_SIZE-1:0] rd_data_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	// a row never written since reset is blank
	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: sim/turtle_grid_plotter_tb.sv
// turtle_grid_plotter_tb: self-checking bench for the turtle grid plotter.
// Drives a directed command table, then random command streams under varied idling and result stalls.
// Depends on tgp_pkg and turtle_grid_plotter.

module turtle_grid_plotter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tgp_pkg::*;

	localparam int GRID_SIZE      = 64;
	localparam int GRID_LAST      = GRID_SIZE - 1;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_WORDS    = 300;

	// spare command codes, no effect on the turtle
	localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

	typedef struct {
		cmd_t word;
		bit   typed;
		rsp_t result;
	} plot_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// turtle and drawing as the plotter should hold them
	logic [GRID_SIZE-1:0] ink [GRID_SIZE];
	logic [5:0]           pos_row;
	logic [5:0]           pos_col;
	logic [1:0]           pos_head;
	logic                 pen_is_down;

	rsp_t      pending_rsp_q [$];
	rsp_t      want_rsp;
	int        err_count;
	int        quiet_cycles;
	int        send_idle_pct;
	int        stall_pct;
	plot_row_t plot_table [26];

	turtle_grid_plotter #(
		.GRID_SIZE(GRID_SIZE)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// apply one command to the turtle state and return the word it should produce
	function automatic rsp_t plot_command(input cmd_t c);
		rsp_t r;
		int   dr;
		int   dc;
		int   tr;
		int   tc;
		int   rr;
		int   cc;
		r = '0;
		case (c.func)
		FUNC_PEN_UP:   pen_is_down = 1'b0;
		FUNC_PEN_DOWN: pen_is_down = 1'b1;
		FUNC_TURN_R:   pos_head = pos_head + 2'd1;
		FUNC_TURN_L:   pos_head = pos_head - 2'd1;
		FUNC_MOVE: begin
			dr = (pos_head == HEAD_SOUTH) ? 1 : (pos_head == HEAD_NORTH) ? -1 : 0;
			dc = (pos_head == HEAD_EAST) ? 1 : (pos_head == HEAD_WEST) ? -1 : 0;
			tr = int'(pos_row) + dr * int'(c.step_count);
			tc = int'(pos_col) + dc * int'(c.step_count);
			if (tr < 0 || tc < 0 || tr > GRID_LAST || tc > GRID_LAST) begin
				r.clipped = 1'b1;
			end
			if (tr < 0) tr = 0;
			if (tc < 0) tc = 0;
			if (tr > GRID_LAST) tr = GRID_LAST;
			if (tc > GRID_LAST) tc = GRID_LAST;
			// mark the path, end cell excluded
			if (pen_is_down) begin
				rr = int'(pos_row);
				cc = int'(pos_col);
				while (rr != tr || cc != tc) begin
					ink[rr][cc] = 1'b1;
					rr += dr;
					cc += dc;
				end
			end
			pos_row = 6'(tr);
			pos_col = 6'(tc);
		end
		FUNC_READ:     r.cell_value = ink[c.read_row][c.read_col];
		default: ;
		endcase
		r.row_now     = pos_row;
		r.col_now     = pos_col;
		r.heading_now = pos_head;
		r.pen_now     = pen_is_down;
		return r;
	endfunction

	// random command, weighted toward drawing and reading back near the turtle
	function automatic cmd_t random_cmd();
		cmd_t c;
		int   pick;
		c.func       = FUNC_PEN_UP;
		c.step_count = 6'($urandom);
		c.read_row   = 6'($urandom);
		c.read_col   = 6'($urandom);
		pick = $urandom_range(99);
		if (pick < 32) begin
			c.func = FUNC_MOVE;
			case ($urandom_range(3))
			0: c.step_count = 6'($urandom_range(8));
			1: c.step_count = 6'($urandom_range(20));
			2: c.step_count = 6'($urandom);
			default: c.step_count = 6'd63;
			endcase
		end else if (pick < 62) begin
			c.func = FUNC_READ;
			case ($urandom_range(4))
			0: c.read_row = pos_row;
			1: c.read_col = pos_col;
			2: begin
				c.read_row = pos_row;
				c.read_col = pos_col + 6'($urandom_range(2)) - 6'd1;
			end
			3: begin
				c.read_col = pos_col;
				c.read_row = pos_row + 6'($urandom_range(2)) - 6'd1;
			end
			default: ;
			endcase
		end else if (pick < 74) begin
			c.func = ($urandom_range(9) < 7) ? FUNC_PEN_DOWN : FUNC_PEN_UP;
		end else if (pick < 94) begin
			c.func = $urandom_range(1) ? FUNC_TURN_R : FUNC_TURN_L;
		end else begin
			c.func = 3'($urandom_range(7));
		end
		return c;
	endfunction

	task automatic send_word(input cmd_t w, input bit typed, input rsp_t typed_rsp);
		rsp_t pred;
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cmd_valid <= 1'b1;
		cmd       <= w;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		pred = plot_command(w);
		pending_rsp_q.push_back(typed ? typed_rsp : pred);
	endtask

	task automatic check_field(input string fname, input logic [5:0] want_v,
			input logic [5:0] got_v);
		if (got_v !== want_v) begin
			if (err_count < 10) begin
				$display("mismatch %s: expected %0d, got %0d at %0t", fname, want_v, got_v,
					$realtime);
			end
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp_q.size() == 0) begin
				if (err_count < 10) begin
					$display("unexpected word %p at %0t", rsp, $realtime);
				end
				err_count++;
			end else begin
				want_rsp = pending_rsp_q.pop_front();
				check_field("cell_value", 6'(want_rsp.cell_value), 6'(rsp.cell_value));
				check_field("row_now", want_rsp.row_now, rsp.row_now);
				check_field("col_now", want_rsp.col_now, rsp.col_now);
				check_field("heading_now", 6'(want_rsp.heading_now), 6'(rsp.heading_now));
				check_field("pen_now", 6'(want_rsp.pen_now), 6'(rsp.pen_now));
				check_field("clipped", 6'(want_rsp.clipped), 6'(rsp.clipped));
			end
		end
	end

	// ends a hung run: counts cycles with no word moving on either side
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cmd_valid     = 1'b0;
		cmd           = '0;
		rsp_stall     = 1'b0;
		err_count     = 0;
		quiet_cycles  = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		pos_row       = '0;
		pos_col       = '0;
		pos_head      = HEAD_EAST;
		pen_is_down   = 1'b0;
		foreach (ink[i]) ink[i] = '0;

		// func, steps, row, col | typed | cell, row, col, heading, pen, clipped
		plot_table = '{
			'{'{FUNC_READ,     6'd0,  6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd0,  6'd0,  HEAD_EAST,  1'b0, 1'b0}},
			'{'{FUNC_READ,     6'd0,  6'd63, 6'd63}, 1'b1,
				'{1'b0, 6'd0,  6'd0,  HEAD_EAST,  1'b0, 1'b0}},
			'{'{FUNC_MOVE,     6'd0,  6'd63, 6'd63}, 1'b1,
				'{1'b0, 6'd0,  6'd0,  HEAD_EAST,  1'b0, 1'b0}},
			'{'{FUNC_PEN_DOWN, 6'd63, 6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd0,  6'd0,  HEAD_EAST,  1'b1, 1'b0}},
			// zero steps with the pen down marks nothing
			'{'{FUNC_MOVE,     6'd0,  6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd0,  6'd0,  HEAD_EAST,  1'b1, 1'b0}},
			'{'{FUNC_READ,     6'd0,  6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd0,  6'd0,  HEAD_EAST,  1'b1, 1'b0}},
			'{'{FUNC_MOVE,     6'd63, 6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd0,  6'd63, HEAD_EAST,  1'b1, 1'b0}},
			'{'{FUNC_READ,     6'd0,  6'd0,  6'd62}, 1'b1,
				'{1'b1, 6'd0,  6'd63, HEAD_EAST,  1'b1, 1'b0}},
			// end cell of a line stays clear
			'{'{FUNC_READ,     6'd0,  6'd0,  6'd63}, 1'b1,
				'{1'b0, 6'd0,  6'd63, HEAD_EAST,  1'b1, 1'b0}},
			'{'{FUNC_MOVE,     6'd1,  6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd0,  6'd63, HEAD_EAST,  1'b1, 1'b1}},
			'{'{FUNC_TURN_R,   6'd0,  6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd0,  6'd63, HEAD_SOUTH, 1'b1, 1'b0}},
			'{'{FUNC_MOVE,     6'd63, 6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd63, 6'd63, HEAD_SOUTH, 1'b1, 1'b0}},
			'{'{FUNC_MOVE,     6'd5,  6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd63, 6'd63, HEAD_SOUTH, 1'b1, 1'b1}},
			'{'{FUNC_TURN_R,   6'd0,  6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd63, 6'd63, HEAD_WEST,  1'b1, 1'b0}},
			'{'{FUNC_MOVE,     6'd40, 6'd0,  6'd0},  1'b0, '0},
			// runs past the west edge while drawing
			'{'{FUNC_MOVE,     6'd40, 6'd0,  6'd0},  1'b0, '0},
			'{'{FUNC_READ,     6'd0,  6'd63, 6'd1},  1'b1,
				'{1'b1, 6'd63, 6'd0,  HEAD_WEST,  1'b1, 1'b0}},
			'{'{FUNC_READ,     6'd0,  6'd63, 6'd0},  1'b1,
				'{1'b0, 6'd63, 6'd0,  HEAD_WEST,  1'b1, 1'b0}},
			'{'{FUNC_TURN_R,   6'd0,  6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd63, 6'd0,  HEAD_NORTH, 1'b1, 1'b0}},
			'{'{FUNC_MOVE,     6'd63, 6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd0,  6'd0,  HEAD_NORTH, 1'b1, 1'b0}},
			// heading wraps both ways
			'{'{FUNC_TURN_R,   6'd0,  6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd0,  6'd0,  HEAD_EAST,  1'b1, 1'b0}},
			'{'{FUNC_TURN_L,   6'd0,  6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd0,  6'd0,  HEAD_NORTH, 1'b1, 1'b0}},
			'{'{FUNC_MOVE,     6'd1,  6'd0,  6'd0},  1'b1,
				'{1'b0, 6'd0,  6'd0,  HEAD_NORTH, 1'b1, 1'b1}},
			'{'{FUNC_PEN_UP,   6'd63, 6'd63, 6'd63}, 1'b1,
				'{1'b0, 6'd0,  6'd0,  HEAD_NORTH, 1'b0, 1'b0}},
			'{'{FUNC_SPARE_6,  6'd63, 6'd63, 6'd63}, 1'b0, '0},
			'{'{FUNC_SPARE_7,  6'd42, 6'd21, 6'd21}, 1'b0, '0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plot_table[i]) begin
			send_word(plot_table[i].word, plot_table[i].typed, plot_table[i].result);
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 54; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 54; end
			default: begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			// hold off new words until the plotter has answered everything
			cmd_valid <= 1'b0;
			do @(posedge clk); while (pending_rsp_q.size() != 0);
			repeat (PHASE_WORDS) send_word(random_cmd(), 1'b0, '0);
		end

		cmd_valid <= 1'b0;
		while (pending_rsp_q.size() != 0) @(posedge clk);
		repeat (GRID_SIZE + 8) @(posedge clk);
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
